// ===== rtl/core/ttcb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttcb_pkg
// Shared types, codes and constants of the text terminal character buffer.
// ----------------------------------------------------------------------------
package ttcb_pkg;

    localparam int ROWS_DEFAULT        = 24;
    localparam int MAX_COLUMNS_DEFAULT = 80;
    localparam int NARROW_COLUMNS      = 40;

    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_EIGHTY   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DIM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK    = 2'd2;

    localparam logic [6:0] CH_MASK   = 7'h7F;
    localparam logic [6:0] CH_CR     = 7'h0D;
    localparam logic [6:0] CH_LOW    = 7'h20;
    localparam logic [6:0] CH_HIGH   = 7'h5F;
    localparam logic [6:0] CH_SPACE  = 7'h20;
    localparam logic [6:0] CH_CURSOR = 7'h40;

    localparam logic [15:0] BLINK_RESET = 16'd250;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FILL,
        ST_READ
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec_op;
        logic rd_issue;
        logic rd_finish;
        logic fill_step;
    } dp_cmd_t;

    typedef struct packed {
        logic is_read;
        logic needs_fill;
        logic fill_last;
    } dp_status_t;

endpackage

// ===== rtl/core/ttcb_ctrl.sv =====
// ----------------------------------------------------------------------------
// ttcb_ctrl
// Sequencer of the character buffer: item intake, row fill, read and result.
// ----------------------------------------------------------------------------
module ttcb_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    input  ttcb_pkg::dp_status_t status,
    output ttcb_pkg::dp_cmd_t    cmd,
    output ttcb_pkg::ctrl_state_t state
);

    ttcb_pkg::ctrl_state_t state_reg;
    ttcb_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ttcb_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ttcb_pkg::ST_EXEC;
                end
            end
            ttcb_pkg::ST_EXEC:
            begin
                if (status.is_read)
                begin
                    state_next = ttcb_pkg::ST_READ;
                end
                else if (status.needs_fill)
                begin
                    state_next = ttcb_pkg::ST_FILL;
                end
                else if (out_free)
                begin
                    state_next = ttcb_pkg::ST_IDLE;
                end
            end
            ttcb_pkg::ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ttcb_pkg::ST_EXEC;
                end
            end
            ttcb_pkg::ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ttcb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ttcb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready      = 1'b0;
        cmd           = '0;
        unique case (state_reg)
            ttcb_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ttcb_pkg::ST_EXEC:
            begin
                cmd.rd_issue = status.is_read;
                cmd.exec_op  = !status.is_read && !status.needs_fill && out_free;
            end
            ttcb_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
            end
            ttcb_pkg::ST_READ:
            begin
                cmd.rd_finish = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.exec_op || cmd.rd_finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttcb_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign state    = state_reg;

endmodule

// ===== rtl/core/ttcb_datapath.sv =====
// ----------------------------------------------------------------------------
// ttcb_datapath
// Character store, row valid bits, cursor, scroll pointer, blink timer,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module ttcb_datapath
#(
    parameter int ROWS        = ttcb_pkg::ROWS_DEFAULT,
    parameter int MAX_COLUMNS = ttcb_pkg::MAX_COLUMNS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ttcb_pkg::IN_DATA_W-1:0]   s_tdata,
    input  logic [ttcb_pkg::IN_USER_W-1:0]   s_tuser,
    output logic [ttcb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [ttcb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttcb_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  ttcb_pkg::dp_cmd_t                cmd,
    output ttcb_pkg::dp_status_t             status
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(MAX_COLUMNS);
    localparam int WW    = CW + 1;
    localparam int CELLS = ROWS * MAX_COLUMNS;
    localparam int AW    = $clog2(CELLS);

    localparam logic [RW:0]   ROWS_R   = (RW+1)'(ROWS);
    localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
    localparam logic [CW-1:0] LAST_COL = CW'(MAX_COLUMNS - 1);

    // configuration
    logic        eighty_reg;
    logic        dim_reg;
    logic [15:0] blink_ticks_reg;
    logic        eighty_next;

    // terminal state
    logic [ROWS-1:0] valid_reg;
    logic [ROWS-1:0] valid_next;
    logic [RW-1:0]   top_reg;
    logic [RW-1:0]   top_next;
    logic [RW-1:0]   cur_row_reg;
    logic [RW-1:0]   cur_row_next;
    logic [CW-1:0]   cur_col_reg;
    logic [CW-1:0]   cur_col_next;
    logic            blink_on_reg;
    logic            blink_on_next;
    logic [15:0]     blink_cnt_reg;
    logic [15:0]     blink_cnt_next;
    logic [CW-1:0]   fill_cnt_reg;
    logic            scrolled;

    // latched item
    logic [1:0] req_reg;
    logic [6:0] ch_reg;
    logic [4:0] rrow_reg;
    logic [6:0] rcol_reg;

    // store
    logic [6:0]    mem [CELLS];
    logic [6:0]    mem_q_reg;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [6:0]    mem_wdata;

    // read path
    logic          rd_row_in;
    logic          rd_in_screen;
    logic [RW-1:0] rd_row_sel;
    logic [CW-1:0] rd_col_sel;
    logic [RW-1:0] rd_phys;
    logic [AW-1:0] rd_addr;
    logic          rd_screen_reg;
    logic          rd_hit_reg;
    logic          rd_valid_reg;
    logic          rd_bold_reg;
    logic [6:0]    rd_cell;

    logic          printable;
    logic          is_cr;
    logic [WW-1:0] width;
    logic [RW-1:0] cur_phys;
    logic [WW-1:0] col_inc;
    logic [16:0]   blink_inc;
    logic          new_line;

    // result
    logic [6:0] out_cell_reg;
    logic       out_bold_reg;
    logic [6:0] out_col_reg;
    logic [4:0] out_line_reg;
    logic       out_scrolled_reg;

    function automatic logic [RW-1:0] phys_row(logic [RW-1:0] top, logic [RW-1:0] r);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, r};
        if (s >= ROWS_R)
        begin
            s = s - ROWS_R;
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c);
        return AW'(AW'(r) * AW'(MAX_COLUMNS)) + AW'(c);
    endfunction

    assign printable = (ch_reg >= ttcb_pkg::CH_LOW) && (ch_reg <= ttcb_pkg::CH_HIGH);
    assign is_cr     = (ch_reg == ttcb_pkg::CH_CR);
    assign width     = eighty_reg ? WW'(MAX_COLUMNS) : WW'(ttcb_pkg::NARROW_COLUMNS);
    assign cur_phys  = phys_row(top_reg, cur_row_reg);
    assign col_inc   = {1'b0, cur_col_reg} + WW'(1);
    assign blink_inc = {1'b0, blink_cnt_reg} + 17'd1;

    assign status.is_read    = (req_reg == ttcb_pkg::REQ_READ);
    assign status.needs_fill = (req_reg == ttcb_pkg::REQ_WRITE) && printable
                               && !valid_reg[cur_phys];
    assign status.fill_last  = (fill_cnt_reg == LAST_COL);

    // read address and cell classification
    assign rd_row_in    = 7'(rrow_reg) < 7'(ROWS);
    assign rd_in_screen = rd_row_in && (8'(rcol_reg) < 8'(width));
    assign rd_row_sel   = rd_in_screen ? RW'(rrow_reg) : '0;
    assign rd_col_sel   = rd_in_screen ? CW'(rcol_reg) : '0;
    assign rd_phys      = phys_row(top_reg, rd_row_sel);
    assign rd_addr      = cell_addr(rd_phys, rd_col_sel);

    always_comb
    begin
        if (!rd_screen_reg)
        begin
            rd_cell = ttcb_pkg::CH_SPACE;
        end
        else if (rd_hit_reg)
        begin
            rd_cell = blink_on_reg ? ttcb_pkg::CH_CURSOR : ttcb_pkg::CH_SPACE;
        end
        else if (rd_valid_reg)
        begin
            rd_cell = mem_q_reg;
        end
        else
        begin
            rd_cell = ttcb_pkg::CH_SPACE;
        end
    end

    // store write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr(cur_phys, cur_col_reg);
        mem_wdata = ch_reg;
        if (cmd.fill_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(cur_phys, fill_cnt_reg);
            mem_wdata = ttcb_pkg::CH_SPACE;
        end
        else if (cmd.exec_op && (req_reg == ttcb_pkg::REQ_WRITE) && printable)
        begin
            mem_we = 1'b1;
        end
    end

    // state update
    always_comb
    begin
        valid_next     = valid_reg;
        top_next       = top_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        blink_on_next  = blink_on_reg;
        blink_cnt_next = blink_cnt_reg;
        eighty_next    = eighty_reg;
        new_line       = 1'b0;
        scrolled       = 1'b0;

        if (cmd.exec_op)
        begin
            case (req_reg)
                ttcb_pkg::REQ_WRITE:
                begin
                    if (is_cr)
                    begin
                        new_line = 1'b1;
                    end
                    else if (printable)
                    begin
                        if (col_inc >= width)
                        begin
                            new_line = 1'b1;
                        end
                        else
                        begin
                            cur_col_next = CW'(col_inc);
                        end
                    end
                end
                ttcb_pkg::REQ_TICK:
                begin
                    if (blink_inc >= {1'b0, blink_ticks_reg})
                    begin
                        blink_on_next  = !blink_on_reg;
                        blink_cnt_next = '0;
                    end
                    else
                    begin
                        blink_cnt_next = blink_inc[15:0];
                    end
                end
                ttcb_pkg::REQ_CLEAR:
                begin
                    valid_next   = '0;
                    cur_row_next = '0;
                    cur_col_next = '0;
                end
                default:
                begin
                    valid_next = valid_reg;
                end
            endcase
        end

        if (new_line)
        begin
            cur_col_next = '0;
            if (cur_row_reg != LAST_ROW)
            begin
                cur_row_next = cur_row_reg + RW'(1);
            end
            else
            begin
                // oldest row becomes the blank bottom row
                valid_next[top_reg] = 1'b0;
                top_next            = (top_reg == LAST_ROW) ? '0 : top_reg + RW'(1);
                scrolled            = 1'b1;
            end
        end

        if (cmd.fill_step && status.fill_last)
        begin
            valid_next[cur_phys] = 1'b1;
        end

        if (cfg_we && (cfg_index == ttcb_pkg::CFG_EIGHTY) && (cfg_wdata[0] != eighty_reg))
        begin
            eighty_next  = cfg_wdata[0];
            valid_next   = '0;
            cur_row_next = '0;
            cur_col_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eighty_reg      <= 1'b0;
            dim_reg         <= 1'b0;
            blink_ticks_reg <= ttcb_pkg::BLINK_RESET;
            valid_reg       <= '0;
            top_reg         <= '0;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            blink_on_reg    <= 1'b1;
            blink_cnt_reg   <= '0;
            fill_cnt_reg    <= '0;
        end
        else
        begin
            eighty_reg    <= eighty_next;
            valid_reg     <= valid_next;
            top_reg       <= top_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            blink_on_reg  <= blink_on_next;
            blink_cnt_reg <= blink_cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ttcb_pkg::CFG_SCAN_DIM: dim_reg         <= cfg_wdata[0];
                    ttcb_pkg::CFG_BLINK:    blink_ticks_reg <= cfg_wdata;
                    default:                dim_reg         <= dim_reg;
                endcase
            end
            if (cmd.capture)
            begin
                fill_cnt_reg <= '0;
            end
            else if (cmd.fill_step)
            begin
                fill_cnt_reg <= fill_cnt_reg + CW'(1);
            end
        end
    end

    // item capture, read staging and result register
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= s_tuser;
            ch_reg   <= s_tdata[6:0] & ttcb_pkg::CH_MASK;
            rrow_reg <= s_tdata[12:8];
            rcol_reg <= s_tdata[19:13];
        end
        if (cmd.rd_issue)
        begin
            rd_screen_reg <= rd_in_screen;
            rd_hit_reg    <= (7'(rrow_reg) == 7'(cur_row_reg))
                             && (8'(rcol_reg) == 8'(cur_col_reg));
            rd_valid_reg  <= valid_reg[rd_phys];
            rd_bold_reg   <= rd_in_screen && !(dim_reg && rrow_reg[0]);
        end
        if (cmd.exec_op)
        begin
            out_cell_reg     <= '0;
            out_bold_reg     <= 1'b0;
            out_col_reg      <= 7'(cur_col_next);
            out_line_reg     <= 5'(cur_row_next);
            out_scrolled_reg <= scrolled;
        end
        else if (cmd.rd_finish)
        begin
            out_cell_reg     <= rd_cell;
            out_bold_reg     <= rd_bold_reg;
            out_col_reg      <= 7'(cur_col_reg);
            out_line_reg     <= 5'(cur_row_reg);
            out_scrolled_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.rd_issue)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    assign m_tdata = {3'b000, out_scrolled_reg, out_line_reg, out_col_reg,
                      out_bold_reg, out_cell_reg};

endmodule

// ===== rtl/core/text_terminal_char_buffer_top.sv =====
// ----------------------------------------------------------------------------
// text_terminal_char_buffer_top
// Scrolling character terminal store with cursor, blink timer and cell reads.
// ----------------------------------------------------------------------------
// tick, clear, carriage return and a write into a filled row pass from idle
// through execute; a cell read adds the read state for the registered store read
// the first write into a row after clear or scroll adds a space fill of the row
// through the single store write port
// reset clears the row valid bits at once; rows not yet filled read as spaces
// a finished result waits in the output register while the next beat enters
module text_terminal_char_buffer_top
#(
    parameter int ROWS        = ttcb_pkg::ROWS_DEFAULT,
    parameter int MAX_COLUMNS = ttcb_pkg::MAX_COLUMNS_DEFAULT
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // char_in[7:0], read_row[12:8], read_col[19:13], zero fill
    input  logic [ttcb_pkg::IN_DATA_W-1:0]   s_tdata,
    // req_type[1:0]
    input  logic [ttcb_pkg::IN_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cell_char[6:0], bold[7], cursor_column[14:8], cursor_line[19:15],
    // scrolled[20], zero fill
    output logic [ttcb_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic                             cfg_we,
    input  logic [ttcb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ttcb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

    ttcb_pkg::dp_cmd_t     cmd;
    ttcb_pkg::dp_status_t  status;
    ttcb_pkg::ctrl_state_t state;

    ttcb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    ttcb_datapath
    #(
        .ROWS        (ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.exec_op, cmd.rd_issue, cmd.rd_finish, cmd.fill_step}))
        else $error("more than one datapath command at once");

    a_fill_back: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill_step && status.fill_last) |=> (state == ttcb_pkg::ST_EXEC))
        else $error("row fill did not return to execute");

    a_read_stage: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_issue |=> (state == ttcb_pkg::ST_READ))
        else $error("read issue not followed by read stage");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.exec_op || cmd.rd_finish))
        else $error("result shown without a result load");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the text terminal character buffer. A behavioral
// copy of the terminal (store, cursor, scroll pointer, blink timer) predicts
// the status beat of every request; a monitor compares each output beat field
// by field. Directed tests cover character filtering, reads off the screen,
// blink, clear and column modes, followed by randomized phases under
// several register settings with random idling and one long output stall.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS        = ttcb_pkg::ROWS_DEFAULT;
    localparam int MAXC        = ttcb_pkg::MAX_COLUMNS_DEFAULT;
    localparam int SETTLE_CYC  = 2 * MAXC + 16;
    localparam int HOLD_CYC    = 300;
    localparam int PHASES      = 10;
    localparam int PHASE_BEATS = 130;

    typedef struct packed {
        logic [6:0] glyph;
        logic       bold;
        logic [6:0] col;
        logic [4:0] line;
        logic       scrolled;
    } term_status_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [ttcb_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic [ttcb_pkg::IN_USER_W-1:0]  s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [ttcb_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_we = 1'b0;
    logic [ttcb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ttcb_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

    // terminal image kept by the bench
    logic [6:0]  screen [0:ROWS-1][0:MAXC-1];
    int          top_ptr;
    int          cur_x;
    int          cur_y;
    bit          blink_vis;
    logic [15:0] blink_cnt;
    bit          wide_mode;
    bit          dim_odd;
    logic [15:0] blink_period;

    term_status_t pending_status[$];
    term_status_t want_st;
    term_status_t got_st;
    int           errors = 0;

    bit sender_idle = 1'b0;
    int stall_pct   = 0;
    int hold_asked  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;

    text_terminal_char_buffer_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int active_cols();
        return wide_mode ? MAXC : ttcb_pkg::NARROW_COLUMNS;
    endfunction

    function automatic void home_clear();
        for (int r = 0; r < ROWS; r++)
            for (int c = 0; c < MAXC; c++)
                screen[r][c] = ttcb_pkg::CH_SPACE;
        cur_x = 0;
        cur_y = 0;
    endfunction

    // carriage return; past the last row the oldest row becomes the blank bottom
    function automatic bit line_feed();
        cur_x = 0;
        if (cur_y + 1 < ROWS)
        begin
            cur_y++;
            return 1'b0;
        end
        for (int c = 0; c < MAXC; c++)
            screen[top_ptr][c] = ttcb_pkg::CH_SPACE;
        top_ptr = (top_ptr + 1) % ROWS;
        return 1'b1;
    endfunction

    function automatic term_status_t apply_request(logic [1:0] req, logic [7:0] raw,
                                                   logic [4:0] rrow, logic [6:0] rcol);
        term_status_t st;
        logic [6:0]   ch;
        int           n;
        st = '0;
        ch = raw[6:0];
        case (req)
            ttcb_pkg::REQ_WRITE:
            begin
                if (ch == ttcb_pkg::CH_CR)
                    st.scrolled = line_feed();
                else if (ch >= ttcb_pkg::CH_LOW && ch <= ttcb_pkg::CH_HIGH)
                begin
                    screen[(top_ptr + cur_y) % ROWS][cur_x] = ch;
                    cur_x++;
                    if (cur_x >= active_cols())
                        st.scrolled = line_feed();
                end
            end
            ttcb_pkg::REQ_READ:
            begin
                if (int'(rrow) < ROWS && int'(rcol) < active_cols())
                begin
                    if (int'(rrow) == cur_y && int'(rcol) == cur_x)
                        st.glyph = blink_vis ? ttcb_pkg::CH_CURSOR : ttcb_pkg::CH_SPACE;
                    else
                        st.glyph = screen[(top_ptr + int'(rrow)) % ROWS][rcol];
                    st.bold = !(dim_odd && rrow[0]);
                end
                else
                    st.glyph = ttcb_pkg::CH_SPACE;
            end
            ttcb_pkg::REQ_TICK:
            begin
                n = int'(blink_cnt) + 1;
                if (n >= int'(blink_period))
                begin
                    blink_vis = !blink_vis;
                    blink_cnt = '0;
                end
                else
                    blink_cnt = n[15:0];
            end
            default:
                home_clear();
        endcase
        st.col  = cur_x[6:0];
        st.line = cur_y[4:0];
        return st;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!sender_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_beat(logic [1:0] req, logic [7:0] ch, logic [4:0] row,
                             logic [6:0] col);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {4'b0, col, row, ch};
        do
            @(posedge clk);
        while (!s_tready);
        pending_status.push_back(apply_request(req, ch, row, col));
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // input quiet, every status beat back, then room for a trailing row fill
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_reg(logic [ttcb_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ttcb_pkg::CFG_EIGHTY:
            begin
                if (val[0] != wide_mode)
                begin
                    wide_mode = val[0];
                    home_clear();
                end
            end
            ttcb_pkg::CFG_SCAN_DIM:
                dim_odd = val[0];
            default:
                blink_period = val;
        endcase
    endtask

    task automatic send_random_beat();
        int         r;
        logic [7:0] ch;
        logic [4:0] row;
        logic [6:0] col;
        r   = $urandom_range(0, 99);
        ch  = $urandom_range(0, 255);
        row = $urandom_range(0, 31);
        col = $urandom_range(0, 127);
        if (r < 40)
        begin
            ch = {1'($urandom_range(0, 1)),
                  7'($urandom_range(ttcb_pkg::CH_LOW, ttcb_pkg::CH_HIGH))};
            send_beat(ttcb_pkg::REQ_WRITE, ch, row, col);
        end
        else if (r < 50)
            send_beat(ttcb_pkg::REQ_WRITE, {1'($urandom_range(0, 1)), ttcb_pkg::CH_CR},
                      row, col);
        else if (r < 56)
            send_beat(ttcb_pkg::REQ_WRITE, ch, row, col);
        else if (r < 82)
        begin
            r = $urandom_range(0, 99);
            if (r < 30)
            begin
                row = cur_y[4:0];
                col = cur_x[6:0];
            end
            else if (r < 85)
            begin
                row = $urandom_range(0, ROWS - 1);
                col = $urandom_range(0, active_cols() - 1);
            end
            send_beat(ttcb_pkg::REQ_READ, ch, row, col);
        end
        else if (r < 98)
            send_beat(ttcb_pkg::REQ_TICK, ch, row, col);
        else
            send_beat(ttcb_pkg::REQ_CLEAR, ch, row, col);
    endtask

    // output side: random stalls, plus a long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asked)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYC;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (stall_pct == 0)
                m_tready <= 1'b1;
            else if ($urandom_range(0, 99) < 3)
            begin
                hold_left = $urandom_range(8, 40);
                m_tready  <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            errors++;
            if (errors < 60)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_st = {m_tdata[6:0], m_tdata[7], m_tdata[14:8], m_tdata[19:15], m_tdata[20]};
            if (pending_status.size() == 0)
            begin
                errors++;
                if (errors < 60)
                    $display("%0t: beat with nothing expected, actual %h", $time, m_tdata);
            end
            else
            begin
                want_st = pending_status.pop_front();
                check_field("cell_char", want_st.glyph, got_st.glyph);
                check_field("bold", want_st.bold, got_st.bold);
                check_field("cursor_column", want_st.col, got_st.col);
                check_field("cursor_line", want_st.line, got_st.line);
                check_field("scrolled", want_st.scrolled, got_st.scrolled);
            end
        end
    end

    task automatic test_power_on();
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd5, 7'd10);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd40);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd24, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'hFF, 5'd31, 7'd127);
    endtask

    task automatic test_char_filter();
        send_beat(ttcb_pkg::REQ_WRITE, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_WRITE, 8'h1F, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_WRITE, 8'h20, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_WRITE, 8'h5F, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_WRITE, 8'h60, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_WRITE, 8'hFF, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_WRITE, 8'hC1, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd1);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd2);
        send_beat(ttcb_pkg::REQ_WRITE, 8'h8D, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_WRITE, 8'h0D, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
    endtask

    task automatic test_blink();
        write_reg(ttcb_pkg::CFG_BLINK, 16'd0);
        send_beat(ttcb_pkg::REQ_TICK, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, cur_y[4:0], cur_x[6:0]);
        send_beat(ttcb_pkg::REQ_TICK, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, cur_y[4:0], cur_x[6:0]);
        write_reg(ttcb_pkg::CFG_BLINK, 16'd2);
        send_beat(ttcb_pkg::REQ_TICK, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_TICK, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, cur_y[4:0], cur_x[6:0]);
    endtask

    task automatic test_clear();
        send_beat(ttcb_pkg::REQ_WRITE, 8'h41, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_CLEAR, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd1);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd2, 7'd0);
    endtask

    task automatic test_column_modes();
        write_reg(ttcb_pkg::CFG_EIGHTY, 16'd1);
        send_beat(ttcb_pkg::REQ_WRITE, 8'h5A, 5'd0, 7'd0);
        write_reg(ttcb_pkg::CFG_EIGHTY, 16'd1);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd79);
        write_reg(ttcb_pkg::CFG_SCAN_DIM, 16'd1);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd1, 7'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
        write_reg(ttcb_pkg::CFG_SCAN_DIM, 16'd0);
        write_reg(ttcb_pkg::CFG_EIGHTY, 16'd0);
        send_beat(ttcb_pkg::REQ_READ, 8'h00, 5'd0, 7'd0);
    endtask

    task automatic test_random_phases();
        logic [15:0] blink_opts [0:7];
        int          k;
        blink_opts = '{16'd0, 16'd1, 16'hFFFF, 16'd2, ttcb_pkg::BLINK_RESET,
                       16'd3, 16'd5, 16'd7};
        for (int ph = 0; ph < PHASES; ph++)
        begin
            k = ph % 3;
            write_reg(ttcb_pkg::CFG_EIGHTY, 16'(ph % 2));
            write_reg(ttcb_pkg::CFG_SCAN_DIM, 16'((ph / 2) % 2));
            write_reg(ttcb_pkg::CFG_BLINK, (ph == PHASES - 1) ? 16'($urandom_range(1, 65535))
                                                              : blink_opts[ph % 8]);
            sender_idle = (k != 0);
            stall_pct   = (k == 0) ? 0 : ((k == 1) ? 25 : 60);
            for (int i = 0; i < PHASE_BEATS; i++)
                send_random_beat();
        end
    endtask

    task automatic test_backpressure();
        sender_idle = 1'b0;
        stall_pct   = 0;
        hold_asked++;
        for (int i = 0; i < 60; i++)
            send_random_beat();
    endtask

    initial
    begin
        wide_mode    = 1'b0;
        dim_odd      = 1'b0;
        blink_period = ttcb_pkg::BLINK_RESET;
        top_ptr      = 0;
        blink_vis    = 1'b1;
        blink_cnt    = '0;
        home_clear();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_char_filter();
        test_blink();
        test_clear();
        test_column_modes();
        test_random_phases();
        test_backpressure();

        settle();
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/ttcb_pkg.sv
rtl/core/ttcb_ctrl.sv
rtl/core/ttcb_datapath.sv
rtl/core/text_terminal_char_buffer_top.sv
tb/tb.sv
